// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL. Both forms sample on i_clk and are
// disabled while i_rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds at every sampled edge.
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/jss_pkg.sv =====
`default_nettype none

package jss_pkg;

    localparam int VALUE_W    = 16;
    localparam int INDEX_W    = 10;
    localparam int RESID_W    = 48;
    localparam int SIZE_W     = 11;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 48;

    localparam int SIZE_MIN   = 3;
    localparam int SIZE_RESET = 1024;
    localparam logic [RESID_W-1:0] THRESH_RESET = RESID_W'(7);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COLUMN_COUNT    = 2'd0,
        CFG_ROW_COUNT       = 2'd1,
        CFG_RESID_THRESHOLD = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [VALUE_W-1:0] cell_value;
    } t_in_item;

    typedef struct packed {
        logic [VALUE_W-1:0] new_value;
        logic [INDEX_W-1:0] row_index;
        logic [INDEX_W-1:0] col_index;
        logic [RESID_W-1:0] residual_sum;
        logic               converged;
        logic               sweep_done;
    } t_out_item;

    // Grid size clamp to SIZE_MIN..hi.
    function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                     input int unsigned hi);
        logic [SIZE_W-1:0] res;
        if (v < SIZE_W'(SIZE_MIN)) begin
            res = SIZE_W'(SIZE_MIN);
        end else if (32'(v) > hi) begin
            res = SIZE_W'(hi);
        end else begin
            res = v;
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/jss_stream_if.sv =====
`default_nettype none

interface jss_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/jacobi_stencil_sweep.sv =====
// One Jacobi sweep of a heat plate with the four-neighbor stencil. Cells of the
// current grid (unsigned Q8.8) come in on i_cells in raster order, row 0 and
// column 0 first. For each cell (r,c) with r >= 2 and c >= 2 one result leaves
// on o_results: the new value of interior cell (r-1,c-1), i.e. the sum of its
// four neighbors shifted right by two (truncated). The squared change against
// the old center value goes into a 48-bit saturating residual; the result for
// the final interior cell has sweep_done set and carries the residual and the
// converged flag (residual <= residual_threshold, both in squared Q8.8 units).
// Border cells give no result. After the last cell of the grid the position
// counters and the residual return to zero, so the next transfer starts a new
// sweep. Sizes written through the config port are clamped to 3..MAX; write
// config only while the block is idle. Throughput: one cell per cycle while
// the skid entry is free. The cell passes four registers: line-store read
// register, stencil/difference stage, square stage, then the accumulate stage
// that loads the output register. A two-entry output (output register plus
// skid) keeps the input open while one result waits; the input stalls only
// once both entries hold a result.
// The two line stores are single-write, single-read RAMs indexed by column;
// they need no clearing after reset, since a sweep writes each entry before it
// uses a value read from it.
`default_nettype none
`include "assert_macros.svh"

module jacobi_stencil_sweep #(
    parameter int MAX_COLUMNS = 1024,
    parameter int MAX_ROWS    = 1024
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // config write port
    input  wire logic                           i_cfg_we,
    input  wire logic [jss_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [jss_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // streams
    jss_stream_if.sink                          i_cells,
    jss_stream_if.source                        o_results
);
    import jss_pkg::*;

    localparam int CW   = $clog2(MAX_COLUMNS);
    localparam int RW   = $clog2(MAX_ROWS);
    localparam int CCMP = ((CW > SIZE_W) ? CW : SIZE_W) + 1;
    localparam int RCMP = ((RW > SIZE_W) ? RW : SIZE_W) + 1;
    localparam int SUM_W = VALUE_W + 2;
    localparam int SQ_W  = 2 * VALUE_W;

    // ---------------- config registers ----------------
    logic [SIZE_W-1:0]  r_column_count;
    logic [SIZE_W-1:0]  r_row_count;
    logic [RESID_W-1:0] r_threshold;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_column_count <= clamp_size(SIZE_W'(SIZE_RESET), MAX_COLUMNS);
            r_row_count    <= clamp_size(SIZE_W'(SIZE_RESET), MAX_ROWS);
            r_threshold    <= THRESH_RESET;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_COLUMN_COUNT: begin
                    r_column_count <= clamp_size(i_cfg_data[SIZE_W-1:0], MAX_COLUMNS);
                end
                CFG_ROW_COUNT: begin
                    r_row_count <= clamp_size(i_cfg_data[SIZE_W-1:0], MAX_ROWS);
                end
                CFG_RESID_THRESHOLD: begin
                    r_threshold <= i_cfg_data[RESID_W-1:0];
                end
                default: ; // unused index, write dropped
            endcase
        end
    end

    // ---------------- flow control ----------------
    // Whole pipeline moves while the skid entry is free.
    logic r_skid_valid;
    logic en;
    logic in_fire;
    logic out_take;

    assign en            = !r_skid_valid;
    assign i_cells.ready = en;
    assign in_fire       = i_cells.valid && en;

    // ---------------- raster position ----------------
    logic [CW-1:0] r_col;
    logic [RW-1:0] r_row;
    logic          row_end;
    logic          last;
    logic          emit;

    assign row_end = CCMP'(r_col) >= (CCMP'(r_column_count) - CCMP'(1));
    assign last    = row_end && (RCMP'(r_row) >= (RCMP'(r_row_count) - RCMP'(1)));
    assign emit    = (RCMP'(r_row) >= RCMP'(2)) && (CCMP'(r_col) >= CCMP'(2));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (in_fire) begin
            priority if (last) begin
                r_col <= '0;
                r_row <= '0;
            end else if (row_end) begin
                r_col <= '0;
                r_row <= r_row + RW'(1);
            end else begin
                r_col <= r_col + CW'(1);
            end
        end
    end

    // ---------------- stage 1: line-store read ----------------
    logic               r_s1_valid;
    logic [VALUE_W-1:0] r_s1_cell;
    logic [CW-1:0]      r_s1_col;
    logic [INDEX_W-1:0] r_s1_row_idx;
    logic [INDEX_W-1:0] r_s1_col_idx;
    logic               r_s1_last;
    logic               r_s1_emit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (en) begin
            r_s1_valid <= in_fire;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_cell    <= i_cells.payload.cell_value;
            r_s1_col     <= r_col;
            r_s1_row_idx <= INDEX_W'(r_row - RW'(1));
            r_s1_col_idx <= INDEX_W'(r_col - CW'(1));
            r_s1_last    <= last;
            r_s1_emit    <= emit;
        end
    end

    logic [VALUE_W-1:0] up1;    // row r-1 at column c
    logic [VALUE_W-1:0] up2;    // row r-2 at column c
    logic               s1_move;

    assign s1_move = en && r_s1_valid;

    jss_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (MAX_COLUMNS)
    ) u_line_up1 (
        .i_clk   (i_clk),
        .i_we    (s1_move),
        .i_waddr (r_s1_col),
        .i_wdata (r_s1_cell),
        .i_re    (in_fire),
        .i_raddr (r_col),
        .o_rdata (up1)
    );

    jss_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (MAX_COLUMNS)
    ) u_line_up2 (
        .i_clk   (i_clk),
        .i_we    (s1_move),
        .i_waddr (r_s1_col),
        .i_wdata (up1),
        .i_re    (in_fire),
        .i_raddr (r_col),
        .o_rdata (up2)
    );

    // Sliding window around the center (r-1,c-1).
    logic [VALUE_W-1:0] r_left0;  // row r-1, col c-1 (center)
    logic [VALUE_W-1:0] r_left1;  // row r-1, col c-2 (west)
    logic [VALUE_W-1:0] r_north;  // row r-2, col c-1
    logic [VALUE_W-1:0] r_south;  // row r,   col c-1

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_left1 <= r_left0;
            r_left0 <= up1;
            r_north <= up2;
            r_south <= r_s1_cell;
        end
    end

    logic [SUM_W-1:0]   nb_sum;
    logic [VALUE_W-1:0] new_val;
    logic [VALUE_W-1:0] diff;

    assign nb_sum  = SUM_W'(r_north) + SUM_W'(r_south) + SUM_W'(r_left1) + SUM_W'(up1);
    assign new_val = nb_sum[SUM_W-1:2];
    assign diff    = (new_val >= r_left0) ? (new_val - r_left0) : (r_left0 - new_val);

    // ---------------- stage 2: stencil result ----------------
    logic               r_s2_valid;
    logic [VALUE_W-1:0] r_s2_value;
    logic [VALUE_W-1:0] r_s2_diff;
    logic [INDEX_W-1:0] r_s2_row_idx;
    logic [INDEX_W-1:0] r_s2_col_idx;
    logic               r_s2_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (en) begin
            r_s2_valid <= r_s1_valid && r_s1_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_s2_value   <= new_val;
            r_s2_diff    <= diff;
            r_s2_row_idx <= r_s1_row_idx;
            r_s2_col_idx <= r_s1_col_idx;
            r_s2_last    <= r_s1_last;
        end
    end

    // ---------------- stage 3: square ----------------
    logic               r_s3_valid;
    logic [SQ_W-1:0]    r_s3_sq;
    logic [VALUE_W-1:0] r_s3_value;
    logic [INDEX_W-1:0] r_s3_row_idx;
    logic [INDEX_W-1:0] r_s3_col_idx;
    logic               r_s3_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
        end else if (en) begin
            r_s3_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en && r_s2_valid) begin
            r_s3_sq      <= SQ_W'(r_s2_diff) * SQ_W'(r_s2_diff);
            r_s3_value   <= r_s2_value;
            r_s3_row_idx <= r_s2_row_idx;
            r_s3_col_idx <= r_s2_col_idx;
            r_s3_last    <= r_s2_last;
        end
    end

    // ---------------- stage 4: accumulate, output ----------------
    logic [RESID_W-1:0] r_acc;
    logic [RESID_W:0]   n_acc_wide;
    logic [RESID_W-1:0] n_acc;
    logic               s3_move;
    t_out_item          result;

    assign s3_move    = en && r_s3_valid;
    assign n_acc_wide = {1'b0, r_acc} + (RESID_W + 1)'(r_s3_sq);
    assign n_acc      = n_acc_wide[RESID_W] ? '1 : n_acc_wide[RESID_W-1:0];

    always_comb begin
        result.new_value    = r_s3_value;
        result.row_index    = r_s3_row_idx;
        result.col_index    = r_s3_col_idx;
        result.residual_sum = r_s3_last ? n_acc : '0;
        result.converged    = r_s3_last && (n_acc <= r_threshold);
        result.sweep_done   = r_s3_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else if (s3_move) begin
            r_acc <= r_s3_last ? '0 : n_acc;
        end
    end

    // Output register plus one skid entry.
    logic      r_out_valid;
    t_out_item r_out;
    t_out_item r_skid;

    assign out_take = r_out_valid && o_results.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (out_take) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end
        end else if (r_s3_valid) begin
            if (!r_out_valid || out_take) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (out_take) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (out_take) begin
                r_out <= r_skid;
            end
        end else if (r_s3_valid) begin
            if (!r_out_valid || out_take) begin
                r_out <= result;
            end else begin
                r_skid <= result;
            end
        end
    end

    assign o_results.valid   = r_out_valid;
    assign o_results.payload = r_out;

    // ---------------- checks ----------------
    `ASSERT_CLK(a_skid_behind_out, r_skid_valid |-> r_out_valid, "skid full with empty output")
    `ASSERT_NEXT(a_acc_clear_on_last, s3_move && r_s3_last, r_acc == '0, "residual not cleared")
    `ASSERT_CLK(a_conv_only_at_end, (o_results.valid && o_results.payload.converged) |-> o_results.payload.sweep_done, "converged off sweep end")
    `ASSERT_CLK(a_interior_only, o_results.valid |-> (o_results.payload.row_index != '0 && o_results.payload.col_index != '0), "border cell emitted")

endmodule

`default_nettype wire

// ===== hw/rtl/jss_ram.sv =====
`default_nettype none

module jss_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule

`default_nettype wire
